// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the sha1 hash stream rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sha1hs_pkg.sv
// ----------------------------------------------------------------------------
// sha1hs_pkg
// types and constants shared by the sha1 hash stream unit and its round engine
// ----------------------------------------------------------------------------
package sha1hs_pkg;

    // input item: one message byte plus flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       last_byte;
    } sha1hs_item_t;

    // result item: 160-bit digest, h0 first
    typedef struct packed {
        logic [31:0] digest_h0;
        logic [31:0] digest_h1;
        logic [31:0] digest_h2;
        logic [31:0] digest_h3;
        logic [31:0] digest_h4;
    } sha1hs_digest_t;

    // commands from the byte sequencer to the round engine
    typedef struct packed {
        logic start;
        logic reload;
    } sha1hs_cmd_t;

    // byte sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_ZERO,
        S_LEN,
        S_WAIT,
        S_DONE
    } sha1hs_state_t;

    // round engine states
    typedef enum logic [1:0] {
        E_IDLE,
        E_ROUND,
        E_FINAL
    } sha1hs_eng_state_t;

    // round constants
    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    // initial hash, h0 in entry 0
    localparam logic [4:0][31:0] H_INIT = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [5:0] FILL_TOP   = 6'd63;

endpackage

// File: hw/rtl/sha1hs_rounds.sv
// ----------------------------------------------------------------------------
// sha1hs_rounds
// iterative sha1 compression: one round per cycle on a shared adder chain,
// message schedule in a 16-word shift line, running hash held here
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1hs_rounds (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1hs_pkg::sha1hs_cmd_t cmd,
    input  logic [511:0]        block,
    output logic                busy,
    output logic [159:0]        hash
);
    import sha1hs_pkg::*;

    sha1hs_eng_state_t state_reg, state_next;
    logic [6:0]        round_reg, round_next;
    logic [4:0][31:0]  h_reg, h_next;
    logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]       a_next, b_next, c_next, d_next, e_next;
    logic [15:0][31:0] w_reg, w_next;

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] w_mix;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            round_reg <= '0;
            h_reg     <= H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            h_reg     <= h_next;
        end
    end

    // working variables and schedule
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        w_reg <= w_next;
    end

    // round function and constant by round range
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
        w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        h_next     = h_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        w_next     = w_reg;

        unique case (state_reg)
            E_IDLE:
            begin
                if (cmd.reload)
                begin
                    h_next = H_INIT;
                end
                if (cmd.start)
                begin
                    for (int k = 0; k < 16; k++)
                    begin
                        w_next[k] = block[511 - 32*k -: 32];
                    end
                    a_next     = h_reg[0];
                    b_next     = h_reg[1];
                    c_next     = h_reg[2];
                    d_next     = h_reg[3];
                    e_next     = h_reg[4];
                    round_next = '0;
                    state_next = E_ROUND;
                end
            end
            E_ROUND:
            begin
                a_next = t_val;
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                for (int k = 0; k < 15; k++)
                begin
                    w_next[k] = w_reg[k + 1];
                end
                w_next[15] = {w_mix[30:0], w_mix[31]};
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = E_FINAL;
                end
            end
            E_FINAL:
            begin
                h_next[0]  = h_reg[0] + a_reg;
                h_next[1]  = h_reg[1] + b_reg;
                h_next[2]  = h_reg[2] + c_reg;
                h_next[3]  = h_reg[3] + d_reg;
                h_next[4]  = h_reg[4] + e_reg;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != E_IDLE);
    assign hash = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};

    // checks
    `CHK_IMP(a_round_range, clk, rst_n, state_reg == E_ROUND, round_reg <= LAST_ROUND,
        "round counter past last round")
    `CHK_IMP(a_final_after_last, clk, rst_n, state_reg == E_FINAL,
        $past(state_reg) == E_ROUND && $past(round_reg) == LAST_ROUND,
        "final add not preceded by last round")
    `CHK_NEXT(a_rounds_continue, clk, rst_n,
        state_reg == E_ROUND && round_reg != LAST_ROUND, state_reg == E_ROUND,
        "round sequence broken early")

endmodule

// File: hw/rtl/sha1_hash_stream_unit.sv
// ----------------------------------------------------------------------------
// sha1_hash_stream_unit
// streaming sha1: packs message bytes into 64-byte blocks, pads the message
// on its last item and returns the 160-bit digest
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------
//  in      | item_valid / item_stall    | item   : data_byte, has_data, last_byte
//  out     | digest_valid / digest_stall| digest : digest_h0 .. digest_h4
//
//  an item that does not fill a block is taken while idle, with no engine wait
//  an item that fills a block stalls the input through 80 rounds, the hash add and handoff
//  a last item pads one byte per cycle while the engine is idle (9 to 72 bytes) and runs one or two
//  compressions before the digest, all on the single round engine
//  reset loads the initial hash and clears fill and length; no clearing pass
//  a held digest stalls only the finish of the next message, not its bytes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_hash_stream_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  sha1hs_pkg::sha1hs_item_t   item,
    output logic                       digest_valid,
    input  logic                       digest_stall,
    output sha1hs_pkg::sha1hs_digest_t digest
);
    import sha1hs_pkg::*;

    sha1hs_state_t  state_reg, state_next;
    sha1hs_state_t  ret_reg, ret_next;
    sha1hs_state_t  target;
    logic [511:0]   buf_reg, buf_next;
    logic [5:0]     fill_reg, fill_next;
    logic [63:0]    bits_reg, bits_next;
    sha1hs_digest_t digest_reg, digest_next;
    logic           digest_valid_reg, digest_valid_next;

    logic           put_en;
    logic [7:0]     put_byte;
    logic           block_full;
    sha1hs_cmd_t    eng_cmd;
    logic           eng_busy;
    logic [159:0]   eng_hash;

    // round engine
    sha1hs_rounds u_rounds (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (eng_cmd),
        .block (buf_next),
        .busy  (eng_busy),
        .hash  (eng_hash)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ret_reg          <= S_IDLE;
            fill_reg         <= '0;
            bits_reg         <= '0;
            digest_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ret_reg          <= ret_next;
            fill_reg         <= fill_next;
            bits_reg         <= bits_next;
            digest_valid_reg <= digest_valid_next;
        end
    end

    // block buffer and digest payload
    always_ff @(posedge clk)
    begin
        buf_reg    <= buf_next;
        digest_reg <= digest_next;
    end

    assign block_full = (fill_reg == FILL_TOP);

    // byte sequencer: message bytes, then pad, zeros and length, with engine waits and the digest handoff
    always_comb
    begin
        state_next        = state_reg;
        ret_next          = ret_reg;
        target            = S_IDLE;
        buf_next          = buf_reg;
        fill_next         = fill_reg;
        bits_next         = bits_reg;
        digest_next       = digest_reg;
        digest_valid_next = digest_valid_reg;
        put_en            = 1'b0;
        put_byte          = '0;
        eng_cmd           = '0;

        // output register drains
        if (digest_valid_reg && !digest_stall)
        begin
            digest_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.has_data)
                    begin
                        put_en    = 1'b1;
                        put_byte  = item.data_byte;
                        bits_next = bits_reg + 64'd8;
                    end
                    target = item.last_byte ? S_PAD80 : S_IDLE;
                    if (put_en && block_full)
                    begin
                        ret_next   = target;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        state_next = target;
                    end
                end
            end
            S_PAD80:
            begin
                put_en   = 1'b1;
                put_byte = PAD_BYTE;
                if (block_full)
                begin
                    ret_next   = S_ZERO;
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (fill_reg == FILL_LEN)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    put_en = 1'b1;
                    if (block_full)
                    begin
                        ret_next   = S_ZERO;
                        state_next = S_WAIT;
                    end
                end
            end
            S_LEN:
            begin
                put_en    = 1'b1;
                put_byte  = bits_reg[63:56];
                bits_next = {bits_reg[55:0], 8'h00};
                if (block_full)
                begin
                    ret_next   = S_DONE;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!eng_busy)
                begin
                    state_next = ret_reg;
                end
            end
            S_DONE:
            begin
                if (!digest_valid_reg || !digest_stall)
                begin
                    digest_next.digest_h0 = eng_hash[159:128];
                    digest_next.digest_h1 = eng_hash[127:96];
                    digest_next.digest_h2 = eng_hash[95:64];
                    digest_next.digest_h3 = eng_hash[63:32];
                    digest_next.digest_h4 = eng_hash[31:0];
                    digest_valid_next     = 1'b1;
                    eng_cmd.reload        = 1'b1;
                    bits_next             = '0;
                    fill_next             = '0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // byte insert, compress on a full block
        if (put_en)
        begin
            buf_next      = {buf_reg[503:0], put_byte};
            fill_next     = fill_reg + 6'd1;
            eng_cmd.start = block_full;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign digest_valid = digest_valid_reg;
    assign digest       = digest_reg;

    // checks
    `CHK_IMP(a_start_when_idle, clk, rst_n, eng_cmd.start, !eng_busy,
        "compression started while engine busy")
    `CHK_IMP(a_len_in_tail, clk, rst_n, state_reg == S_LEN, fill_reg >= FILL_LEN,
        "length bytes outside block tail")
    `CHK_IMP(a_done_clean, clk, rst_n, state_reg == S_DONE,
        fill_reg == '0 && bits_reg == '0,
        "message not fully flushed at finish")

endmodule
